FILE: src/go_back_n_endpoint_assert.svh
// Assertion macros for the Go-Back-N endpoint.
`ifndef GO_BACK_N_ENDPOINT_ASSERT_SVH
`define GO_BACK_N_ENDPOINT_ASSERT_SVH
`ifndef SYNTH
`define GBN_ASSERT_HOLD(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
		else $error("invariant violated");
`define GBN_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("implication violated");
`else
`define GBN_ASSERT_HOLD(lbl, ck, rn, cond)
`define GBN_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: src/gbn_pkg.sv
// Types and constants shared by the Go-Back-N endpoint.
`default_nettype none
package gbn_pkg;
	localparam int WINDOW_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam logic [15:0] TIMEOUT_RST = 16'd35;
	localparam logic [4:0] WLIMIT_RST = 5'd10;
	localparam logic [31:0] ACK_NONE = 32'hFFFF_FFFF;
	localparam logic [31:0] ACK_NAK = 32'hFFFF_FFFE;

	localparam logic [1:0] MODE_MSG = 2'd0;
	localparam logic [1:0] MODE_PKT = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	localparam logic [2:0] KIND_DATA = 3'd0;
	localparam logic [2:0] KIND_ACK = 3'd1;
	localparam logic [2:0] KIND_NAK = 3'd2;
	localparam logic [2:0] KIND_DELIVER = 3'd3;
	localparam logic [2:0] KIND_DROP = 3'd4;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_WLIMIT = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [31:0] in_seqnum;
		logic signed [31:0] in_acknum;
		logic signed [31:0] in_checksum;
		logic [12:0] payload_sum;
		logic [31:0] payload_tag;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic signed [31:0] out_seqnum;
		logic signed [31:0] out_acknum;
		logic signed [31:0] out_checksum;
		logic [12:0] out_payload_sum;
		logic [31:0] out_payload_tag;
		logic last;
	} res_t;
endpackage
`default_nettype wire

FILE: src/gbn_alu.sv
// Shared checksum adder: two words plus a payload byte sum.
`default_nettype none
module gbn_alu (
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	input wire logic [12:0] c,
	output logic [31:0] sum
);
	assign sum = a + b + {19'd0, c};
endmodule
`default_nettype wire

FILE: src/go_back_n_endpoint.sv
// Go-Back-N endpoint: sequencer, window and queue memories, timer.
// After a request is taken the input stalls until the sequencer is back in idle, whether for a message,
// a tick without expiry, a packet plus each message refilled from the queue, or a tick that
// expires plus each resent window entry. Each result waits in a hold register, then leaves
// through the output register one per cycle while res_stall is low; a stalled output holds
// the sequencer. Reset clears control state; memories are not cleared.
`default_nettype none
`include "go_back_n_endpoint_assert.svh"
module go_back_n_endpoint #(
	parameter int WINDOW_DEPTH = gbn_pkg::WINDOW_DEPTH_DEF,
	parameter int QUEUE_DEPTH = gbn_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire gbn_pkg::req_t req,
	output logic res_valid,
	input wire logic res_stall,
	output gbn_pkg::res_t res,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [15:0] cfg_data
);
	localparam int WIW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int QIW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [31:0] tag;
		logic [12:0] sum;
		logic [31:0] stamp;
	} win_ent_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [12:0] sum;
	} q_ent_t;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_MSG = 14'b00000000000010,
		S_CHK = 14'b00000000000100,
		S_RX = 14'b00000000001000,
		S_RX2 = 14'b00000000010000,
		S_ACK = 14'b00000000100000,
		S_REF_RD = 14'b00000001000000,
		S_REF_WR = 14'b00000010000000,
		S_ARM_RD = 14'b00000100000000,
		S_ARM = 14'b00001000000000,
		S_TICK = 14'b00010000000000,
		S_RS_RD = 14'b00100000000000,
		S_RS_EM = 14'b01000000000000,
		S_FIN = 14'b10000000000000
	} state_t;

	state_t st_q;
	gbn_pkg::req_t it_q;
	logic good_q;
	logic [WIW:0] i_q;
	logic [31:0] rs_seq_q;
	logic [15:0] to_q;
	logic [4:0] wl_q;
	logic [31:0] base_q, next_q, exp_q, lack_q, tick_q;
	logic [WIW-1:0] ptr_q;
	logic [QIW-1:0] qhead_q, qtail_q;
	logic [QCW-1:0] qcnt_q;
	logic [16:0] tleft_q;
	logic trun_q;
	gbn_pkg::res_t pnd_q, out_q;
	logic pnd_v_q, out_v_q;

	win_ent_t win_mem [WINDOW_DEPTH];
	win_ent_t win_rd_q;
	q_ent_t q_mem [QUEUE_DEPTH];
	q_ent_t q_rd_q;

	logic [31:0] infl, lim32, alu_a, alu_b, alu_sum, ack_u, ack_off, shift32, age;
	logic [12:0] alu_c;
	logic room, q_room, slot_free, emit_ok, emit_v, adv, out_load;
	gbn_pkg::res_t emit_r, out_d;
	logic win_we, q_we;
	logic [WIW-1:0] win_wa, win_ra;
	win_ent_t win_wd;

	function automatic logic [WIW-1:0] phys(input logic [WIW-1:0] p, input logic [WIW:0] off);
		logic [WIW:0] s;
		s = {1'b0, p} + off;
		if (s >= (WIW+1)'(WINDOW_DEPTH)) begin
			s = s - (WIW+1)'(WINDOW_DEPTH);
		end
		return s[WIW-1:0];
	endfunction

	gbn_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.c(alu_c),
		.sum(alu_sum)
	);

	assign infl = next_q - base_q;
	assign ack_u = it_q.in_acknum;
	assign ack_off = ack_u - base_q;
	assign shift32 = ack_u + 32'd1 - base_q;
	assign age = tick_q - win_rd_q.stamp;
	always_comb begin
		if (wl_q == 5'd0) begin
			lim32 = 32'd1;
		end else if ({27'd0, wl_q} > 32'(WINDOW_DEPTH)) begin
			lim32 = 32'(WINDOW_DEPTH);
		end else begin
			lim32 = {27'd0, wl_q};
		end
	end
	assign room = infl < lim32;
	assign q_room = qcnt_q < QCW'(QUEUE_DEPTH);
	assign slot_free = !out_v_q || !res_stall;
	assign emit_ok = !pnd_v_q || slot_free;
	assign req_stall = (st_q != S_IDLE);
	assign res_valid = out_v_q;
	assign res = out_q;

	always_comb begin
		emit_v = 1'b0;
		emit_r = '0;
		alu_a = '0;
		alu_b = '0;
		alu_c = '0;
		win_ra = ptr_q;
		case (st_q)
			S_MSG: begin
				alu_a = next_q;
				alu_b = lack_q;
				alu_c = it_q.payload_sum;
				if (room) begin
					emit_v = 1'b1;
					emit_r = '{gbn_pkg::KIND_DATA, next_q, lack_q, alu_sum,
						it_q.payload_sum, it_q.payload_tag, 1'b0};
				end else if (!q_room) begin
					emit_v = 1'b1;
					emit_r = '{gbn_pkg::KIND_DROP, 32'd0, 32'd0, 32'd0,
						it_q.payload_sum, it_q.payload_tag, 1'b0};
				end
			end
			S_CHK: begin
				alu_a = it_q.in_seqnum;
				alu_b = it_q.in_acknum;
				alu_c = it_q.payload_sum;
			end
			S_RX: begin
				alu_a = gbn_pkg::ACK_NONE;
				alu_b = lack_q;
				if (!good_q) begin
					emit_v = 1'b1;
					emit_r = '{gbn_pkg::KIND_NAK, gbn_pkg::ACK_NONE, gbn_pkg::ACK_NAK,
						gbn_pkg::ACK_NONE + gbn_pkg::ACK_NAK, 13'd0, 32'd0, 1'b0};
				end else if (it_q.in_seqnum == exp_q) begin
					emit_v = 1'b1;
					emit_r = '{gbn_pkg::KIND_DELIVER, it_q.in_seqnum, 32'd0, 32'd0,
						it_q.payload_sum, it_q.payload_tag, 1'b0};
				end else if (!it_q.in_seqnum[31]) begin
					emit_v = 1'b1;
					emit_r = '{gbn_pkg::KIND_ACK, gbn_pkg::ACK_NONE, lack_q, alu_sum,
						13'd0, 32'd0, 1'b0};
				end
			end
			S_RX2: begin
				alu_a = gbn_pkg::ACK_NONE;
				alu_b = it_q.in_seqnum;
				emit_v = 1'b1;
				emit_r = '{gbn_pkg::KIND_ACK, gbn_pkg::ACK_NONE, it_q.in_seqnum, alu_sum,
					13'd0, 32'd0, 1'b0};
			end
			S_REF_WR: begin
				alu_a = next_q;
				alu_b = lack_q;
				alu_c = q_rd_q.sum;
				emit_v = 1'b1;
				emit_r = '{gbn_pkg::KIND_DATA, next_q, lack_q, alu_sum,
					q_rd_q.sum, q_rd_q.tag, 1'b0};
			end
			S_RS_RD: begin
				win_ra = phys(ptr_q, i_q);
			end
			S_RS_EM: begin
				win_ra = phys(ptr_q, i_q);
				alu_a = rs_seq_q;
				alu_b = lack_q;
				alu_c = win_rd_q.sum;
				emit_v = 1'b1;
				emit_r = '{gbn_pkg::KIND_DATA, rs_seq_q, lack_q, alu_sum,
					win_rd_q.sum, win_rd_q.tag, 1'b0};
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
		adv = !emit_v || emit_ok;
		out_d = pnd_q;
		if (st_q == S_FIN) begin
			out_d.last = 1'b1;
		end
		out_load = pnd_v_q && ((emit_v && adv) || (st_q == S_FIN && slot_free));
		win_we = adv && ((st_q == S_MSG && room) || st_q == S_REF_WR || st_q == S_RS_EM);
		q_we = (st_q == S_MSG) && !room && q_room;
		win_wa = phys(ptr_q, infl[WIW:0]);
		win_wd = '{it_q.payload_tag, it_q.payload_sum, tick_q};
		if (st_q == S_REF_WR) begin
			win_wd = '{q_rd_q.tag, q_rd_q.sum, tick_q};
		end else if (st_q == S_RS_EM) begin
			win_wa = phys(ptr_q, i_q);
			win_wd = '{win_rd_q.tag, win_rd_q.sum, tick_q};
		end
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_wa] <= win_wd;
		end
		win_rd_q <= win_mem[win_ra];
		if (q_we) begin
			q_mem[qtail_q] <= '{it_q.payload_tag, it_q.payload_sum};
		end
		q_rd_q <= q_mem[qhead_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			to_q <= gbn_pkg::TIMEOUT_RST;
			wl_q <= gbn_pkg::WLIMIT_RST;
			base_q <= 32'd1;
			next_q <= 32'd1;
			exp_q <= 32'd1;
			lack_q <= gbn_pkg::ACK_NONE;
			ptr_q <= '0;
			qhead_q <= '0;
			qtail_q <= '0;
			qcnt_q <= '0;
			tick_q <= '0;
			tleft_q <= '0;
			trun_q <= 1'b0;
			pnd_v_q <= 1'b0;
			out_v_q <= 1'b0;
			good_q <= 1'b0;
			i_q <= '0;
			rs_seq_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gbn_pkg::CFG_TIMEOUT) begin
					to_q <= cfg_data;
				end else begin
					wl_q <= cfg_data[4:0];
				end
			end
			if (out_load) begin
				out_q <= out_d;
				out_v_q <= 1'b1;
			end else if (out_v_q && !res_stall) begin
				out_v_q <= 1'b0;
			end
			if (emit_v && adv) begin
				pnd_q <= emit_r;
				pnd_v_q <= 1'b1;
			end
			case (st_q)
				S_IDLE: begin
					if (req_valid) begin
						it_q <= req;
						case (req.mode)
							gbn_pkg::MODE_MSG: st_q <= S_MSG;
							gbn_pkg::MODE_PKT: st_q <= S_CHK;
							gbn_pkg::MODE_TICK: st_q <= S_TICK;
							default: st_q <= S_FIN;
						endcase
					end
				end
				S_MSG: begin
					if (adv) begin
						if (room) begin
							next_q <= next_q + 32'd1;
							if (infl == 32'd0 && !trun_q) begin
								trun_q <= 1'b1;
								tleft_q <= {1'b0, to_q};
							end
						end else if (q_room) begin
							qtail_q <= (qtail_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : qtail_q + 1'b1;
							qcnt_q <= qcnt_q + 1'b1;
						end
						st_q <= S_FIN;
					end
				end
				S_CHK: begin
					good_q <= (alu_sum == it_q.in_checksum);
					st_q <= S_RX;
				end
				S_RX: begin
					if (adv) begin
						st_q <= (good_q && it_q.in_seqnum == exp_q) ? S_RX2 : S_ACK;
					end
				end
				S_RX2: begin
					if (adv) begin
						lack_q <= it_q.in_seqnum;
						exp_q <= exp_q + 32'd1;
						st_q <= S_ACK;
					end
				end
				S_ACK: begin
					if (good_q && !ack_u[31] && ack_u != 32'd0 && ack_off < infl) begin
						base_q <= ack_u + 32'd1;
						ptr_q <= phys(ptr_q, shift32[WIW:0]);
						st_q <= S_REF_RD;
					end else begin
						st_q <= S_FIN;
					end
				end
				S_REF_RD: begin
					st_q <= (qcnt_q != '0 && room) ? S_REF_WR : S_ARM_RD;
				end
				S_REF_WR: begin
					if (adv) begin
						next_q <= next_q + 32'd1;
						qhead_q <= (qhead_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : qhead_q + 1'b1;
						qcnt_q <= qcnt_q - 1'b1;
						st_q <= S_REF_RD;
					end
				end
				S_ARM_RD: begin
					trun_q <= 1'b0;
					tleft_q <= '0;
					st_q <= (base_q != next_q) ? S_ARM : S_FIN;
				end
				S_ARM: begin
					trun_q <= 1'b1;
					if (age >= {16'd0, to_q}) begin
						tleft_q <= '0;
					end else begin
						tleft_q <= {1'b0, to_q - age[15:0]};
					end
					st_q <= S_FIN;
				end
				S_TICK: begin
					tick_q <= tick_q + 32'd1;
					if (!trun_q) begin
						st_q <= S_FIN;
					end else if (tleft_q > 17'd1) begin
						tleft_q <= tleft_q - 17'd1;
						st_q <= S_FIN;
					end else begin
						tleft_q <= {1'b0, to_q};
						i_q <= '0;
						rs_seq_q <= base_q;
						st_q <= S_RS_RD;
					end
				end
				S_RS_RD: begin
					st_q <= ({{(31 - WIW){1'b0}}, i_q} < infl) ? S_RS_EM : S_FIN;
				end
				S_RS_EM: begin
					if (adv) begin
						i_q <= i_q + 1'b1;
						rs_seq_q <= rs_seq_q + 32'd1;
						st_q <= S_RS_RD;
					end
				end
				S_FIN: begin
					if (!pnd_v_q) begin
						st_q <= S_IDLE;
					end else if (slot_free) begin
						pnd_v_q <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	`GBN_ASSERT_HOLD(a_qcnt_bound, clk, arst_n, qcnt_q <= QCW'(QUEUE_DEPTH))
	`GBN_ASSERT_HOLD(a_infl_bound, clk, arst_n, (next_q - base_q) <= 32'(WINDOW_DEPTH))
	`GBN_ASSERT_IMPL(a_idle_no_pend, clk, arst_n, st_q == S_IDLE, !pnd_v_q)
endmodule
`default_nettype wire
